FILE: rtl/core/ultrasonic_range_poll_controller_defines.svh
// Assertion macros for the ultrasonic range poll controller.
// Each use expects clk_i and rst_ni in scope.
`ifndef ULTRASONIC_RANGE_POLL_CONTROLLER_DEFINES_SVH
`define ULTRASONIC_RANGE_POLL_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define URP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("urp assertion failed");

`define URP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("urp assertion failed");

`define URP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("urp assertion failed");

`else

`define URP_ASSERT(lbl, prop)
`define URP_ASSERT_IMPLIES(lbl, ante, cons)
`define URP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/urp_pkg.sv
package urp_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // result kinds
  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // configuration register indexes
  localparam int unsigned      CFG_IDX_W         = 3;
  localparam int unsigned      CFG_DATA_W        = 16;
  localparam logic [2:0]       REG_SENSOR_ADDR   = 3'd0;
  localparam logic [2:0]       REG_MIN_RANGE     = 3'd1;
  localparam logic [2:0]       REG_MAX_RANGE     = 3'd2;
  localparam logic [2:0]       REG_READ_TIMEOUT  = 3'd3;
  localparam logic [2:0]       REG_SETTLE        = 3'd4;

  localparam logic [10:0] QUERY_ID_BASE     = 11'h520;
  localparam logic [7:0]  FUNC_READ_REPLY   = 8'h83;
  localparam logic [7:0]  REPLY_PAYLOAD_LEN = 8'h02;
  localparam logic [3:0]  REPLY_MIN_LEN     = 4'd5;
  localparam logic [15:0] VAL_NO_OBJECT     = 16'hFFFD;
  localparam logic [15:0] VAL_INTERFERENCE  = 16'hFFFE;
  localparam logic [15:0] TICK_MAX          = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  sensor_address;
    logic [15:0] min_range_mm;
    logic [15:0] max_range_mm;
    logic [15:0] read_timeout_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } reply_t;

  function automatic logic [10:0] query_id(input logic [7:0] addr);
    query_id = QUERY_ID_BASE + {3'b000, addr};
  endfunction

  // equal keeps the first; otherwise prefer a nonzero low byte, newer wins a tie
  function automatic logic [15:0] reconcile(input logic [15:0] r1, input logic [15:0] r2);
    logic lo1;
    logic lo2;
    lo1 = (r1[7:0] != 8'h00);
    lo2 = (r2[7:0] != 8'h00);
    if (r1 == r2) begin
      reconcile = r1;
    end else if (lo1 && !lo2) begin
      reconcile = r1;
    end else begin
      reconcile = r2;
    end
  endfunction

endpackage

FILE: rtl/core/urp_cfg_regs.sv
module urp_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [urp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [urp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output urp_pkg::cfg_t                      cfg_o
);
  import urp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_address     <= 8'd1;
      cfg_q.min_range_mm       <= 16'd30;
      cfg_q.max_range_mm       <= 16'd5000;
      cfg_q.read_timeout_ticks <= 16'd100;
      cfg_q.settle_ticks       <= 16'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SENSOR_ADDR:  cfg_q.sensor_address     <= cfg_wdata_i[7:0];
        REG_MIN_RANGE:    cfg_q.min_range_mm       <= cfg_wdata_i;
        REG_MAX_RANGE:    cfg_q.max_range_mm       <= cfg_wdata_i;
        REG_READ_TIMEOUT: cfg_q.read_timeout_ticks <= cfg_wdata_i;
        REG_SETTLE:       cfg_q.settle_ticks       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/urp_reply_parse.sv
module urp_reply_parse (
  input  logic [7:0]       sensor_address_i,
  input  logic [10:0]      rx_id_i,
  input  logic [3:0]       rx_len_i,
  input  logic [7:0]       rx_byte0_i,
  input  logic [7:0]       rx_byte1_i,
  input  logic [7:0]       rx_byte2_i,
  input  logic [7:0]       rx_byte3_i,
  input  logic [7:0]       rx_byte4_i,
  output urp_pkg::reply_t  reply_o
);
  import urp_pkg::*;

  logic [15:0] value;
  logic        hdr_ok;

  assign value  = {rx_byte3_i, rx_byte4_i};
  assign hdr_ok = (rx_id_i == query_id(sensor_address_i))
               && (rx_len_i >= REPLY_MIN_LEN)
               && (rx_byte0_i == sensor_address_i)
               && (rx_byte1_i == FUNC_READ_REPLY)
               && (rx_byte2_i == REPLY_PAYLOAD_LEN);

  // no-object and interference codes are not readings
  assign reply_o.ok    = hdr_ok && (value != VAL_NO_OBJECT) && (value != VAL_INTERFERENCE);
  assign reply_o.value = value;

endmodule

FILE: rtl/core/urp_poll_fsm.sv
`include "ultrasonic_range_poll_controller_defines.svh"

module urp_poll_fsm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  urp_pkg::cfg_t   cfg_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  logic [1:0]      cmd_i,
  input  urp_pkg::reply_t reply_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kind_o,
  output logic [10:0]     tx_id_o,
  output logic [15:0]     range_mm_o
);
  import urp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ1,
    PH_SETTLE,
    PH_READ2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] first_q, first_d;
  logic        out_valid_q;
  logic        kind_q;
  logic [10:0] tx_id_q;
  logic [15:0] range_q;

  logic        out_free;
  logic        proc;
  logic [15:0] tick_inc;
  logic [15:0] report_val;
  logic        want_query;
  logic        want_report;
  logic        res_valid;

  assign out_free     = !out_valid_q || out_ready_i;
  assign item_ready_o = out_free;
  assign proc         = item_valid_i && out_free;
  assign tick_inc     = (tick_q == TICK_MAX) ? tick_q : tick_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    first_d     = first_q;
    want_query  = 1'b0;
    want_report = 1'b0;
    report_val  = first_q;
    if (proc) begin
      case (cmd_i)
        CMD_START: begin
          phase_d    = PH_READ1;
          tick_d     = '0;
          want_query = 1'b1;
        end
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            tick_d = tick_inc;
          end
          unique case (phase_q)
            PH_IDLE: ;
            PH_READ1: begin
              if (tick_inc >= cfg_i.read_timeout_ticks) begin
                phase_d = PH_IDLE;
                tick_d  = '0;
              end
            end
            PH_SETTLE: begin
              if (tick_inc >= cfg_i.settle_ticks) begin
                phase_d    = PH_READ2;
                tick_d     = '0;
                want_query = 1'b1;
              end
            end
            PH_READ2: begin
              // second read lost: fall back to the first reading
              if (tick_inc >= cfg_i.read_timeout_ticks) begin
                phase_d     = PH_IDLE;
                tick_d      = '0;
                want_report = 1'b1;
              end
            end
            default: ;
          endcase
        end
        CMD_FRAME: begin
          if (reply_i.ok && (phase_q == PH_READ1 || phase_q == PH_READ2)) begin
            tick_d = '0;
            if (phase_q == PH_READ1) begin
              first_d = reply_i.value;
              if (cfg_i.settle_ticks == 16'd0) begin
                phase_d    = PH_READ2;
                want_query = 1'b1;
              end else begin
                phase_d = PH_SETTLE;
              end
            end else begin
              phase_d     = PH_IDLE;
              want_report = 1'b1;
              report_val  = reconcile(first_q, reply_i.value);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid = want_query
                  || (want_report && report_val >= cfg_i.min_range_mm
                                  && report_val <= cfg_i.max_range_mm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_QUERY;
      tx_id_q     <= '0;
      range_q     <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      first_q <= first_d;
      if (out_free) begin
        out_valid_q <= res_valid;
        if (res_valid) begin
          kind_q  <= want_query ? KIND_QUERY : KIND_REPORT;
          tx_id_q <= want_query ? query_id(cfg_i.sensor_address) : 11'd0;
          range_q <= want_query ? 16'd0 : report_val;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign tx_id_o     = tx_id_q;
  assign range_mm_o  = range_q;

  `URP_ASSERT(a_idle_tick_clear, (phase_q != PH_IDLE) || (tick_q == 16'd0))
  `URP_ASSERT_NEXT(a_start_enters_read1, proc && (cmd_i == CMD_START), phase_q == PH_READ1 && out_valid_q && kind_q == KIND_QUERY)
  `URP_ASSERT_IMPLIES(a_report_in_range, out_valid_q && kind_q == KIND_REPORT, range_q >= cfg_i.min_range_mm && range_q <= cfg_i.max_range_mm && tx_id_q == 11'd0)
  `URP_ASSERT_IMPLIES(a_query_id, out_valid_q && kind_q == KIND_QUERY, tx_id_q == query_id(cfg_i.sensor_address) && range_q == 16'd0)

endmodule

FILE: rtl/core/ultrasonic_range_poll_controller.sv
// Ultrasonic range poll controller. A start request emits a read query on
// CAN id 0x520 plus sensor_address; received frames and tick requests then
// drive the two-read poll, and a reconciled in-range distance comes out as
// a range report. Each request is captured in an input register, decoded
// against the poll state, and any result lands in an output register;
// one request is accepted per cycle as long as results are taken. The only
// back pressure comes from the output register while its result waits.
// Configuration writes take effect on the next cycle.
module ultrasonic_range_poll_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [10:0]                    rx_id_i,
  input  logic [3:0]                     rx_len_i,
  input  logic [7:0]                     rx_byte0_i,
  input  logic [7:0]                     rx_byte1_i,
  input  logic [7:0]                     rx_byte2_i,
  input  logic [7:0]                     rx_byte3_i,
  input  logic [7:0]                     rx_byte4_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [10:0]                    tx_id_o,
  output logic [15:0]                    range_mm_o
);
  import urp_pkg::*;

  cfg_t        cfg;
  reply_t      reply;
  logic        s1_valid_q;
  logic        s1_ready;
  logic [1:0]  cmd_q;
  logic [10:0] rx_id_q;
  logic [3:0]  rx_len_q;
  logic [7:0]  b0_q, b1_q, b2_q, b3_q, b4_q;

  assign in_ready_o = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      rx_id_q  <= rx_id_i;
      rx_len_q <= rx_len_i;
      b0_q     <= rx_byte0_i;
      b1_q     <= rx_byte1_i;
      b2_q     <= rx_byte2_i;
      b3_q     <= rx_byte3_i;
      b4_q     <= rx_byte4_i;
    end
  end

  urp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  urp_reply_parse u_parse (
    .sensor_address_i (cfg.sensor_address),
    .rx_id_i          (rx_id_q),
    .rx_len_i         (rx_len_q),
    .rx_byte0_i       (b0_q),
    .rx_byte1_i       (b1_q),
    .rx_byte2_i       (b2_q),
    .rx_byte3_i       (b3_q),
    .rx_byte4_i       (b4_q),
    .reply_o          (reply)
  );

  urp_poll_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (s1_valid_q),
    .item_ready_o (s1_ready),
    .cmd_i        (cmd_q),
    .reply_i      (reply),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_id_o      (tx_id_o),
    .range_mm_o   (range_mm_o)
  );

endmodule

FILE: tb/sv/ultrasonic_range_poll_controller_tb.sv
module ultrasonic_range_poll_controller_tb;
  import urp_pkg::*;

  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 112;
  localparam int unsigned BREAK_KINDS     = 7;

  typedef enum logic [1:0] {POLL_IDLE, POLL_FIRST, POLL_SETTLE, POLL_SECOND} poll_state_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [10:0]     id;
    logic [3:0]      len;
    logic [4:0][7:0] data;
  } can_req_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] tx_id;
    logic [15:0] range_mm;
  } poll_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            cmd_i       = '0;
  logic [10:0]           rx_id_i     = '0;
  logic [3:0]            rx_len_i    = '0;
  logic [7:0]            rx_byte0_i  = '0;
  logic [7:0]            rx_byte1_i  = '0;
  logic [7:0]            rx_byte2_i  = '0;
  logic [7:0]            rx_byte3_i  = '0;
  logic [7:0]            rx_byte4_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  kind_o;
  logic [10:0]           tx_id_o;
  logic [15:0]           range_mm_o;

  // shadow of the block's poll state and registers
  cfg_t        cfg_shadow = {8'd1, 16'd30, 16'd5000, 16'd100, 16'd50};
  poll_state_e poll_state = POLL_IDLE;
  logic [15:0] tick_cnt   = '0;
  logic [15:0] first_mm   = '0;

  poll_result_t expected_results[$];
  int unsigned  mismatches   = 0;
  int unsigned  burst_left   = 0;
  int unsigned  quiet_cycles = 0;
  logic [15:0]  ready_pattern = 16'hFFFF;
  logic [6:0]   pattern_pos   = '0;

  ultrasonic_range_poll_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .rx_id_i     (rx_id_i),
    .rx_len_i    (rx_len_i),
    .rx_byte0_i  (rx_byte0_i),
    .rx_byte1_i  (rx_byte1_i),
    .rx_byte2_i  (rx_byte2_i),
    .rx_byte3_i  (rx_byte3_i),
    .rx_byte4_i  (rx_byte4_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .tx_id_o     (tx_id_o),
    .range_mm_o  (range_mm_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [10:0] sensor_id();
    return QUERY_ID_BASE + {3'b000, cfg_shadow.sensor_address};
  endfunction

  function automatic void expect_result(input poll_result_t res);
    expected_results = {expected_results, res};
  endfunction

  function automatic void push_query();
    expect_result({KIND_QUERY, sensor_id(), 16'd0});
  endfunction

  function automatic void push_report(input logic [15:0] mm);
    if (mm >= cfg_shadow.min_range_mm && mm <= cfg_shadow.max_range_mm) begin
      expect_result({KIND_REPORT, 11'd0, mm});
    end
  endfunction

  // advance the shadow poll by one accepted request
  function automatic void predict_poll_step(input can_req_t req);
    logic [15:0] reply_mm;
    logic        reply_ok;
    reply_mm = {req.data[3], req.data[4]};
    reply_ok = req.id == sensor_id() && req.len >= REPLY_MIN_LEN &&
               req.data[0] == cfg_shadow.sensor_address && req.data[1] == FUNC_READ_REPLY &&
               req.data[2] == REPLY_PAYLOAD_LEN && reply_mm != VAL_NO_OBJECT &&
               reply_mm != VAL_INTERFERENCE;
    case (req.cmd)
      CMD_START: begin
        poll_state = POLL_FIRST;
        tick_cnt = '0;
        push_query();
      end
      CMD_TICK: begin
        if (poll_state != POLL_IDLE) begin
          if (tick_cnt != TICK_MAX) tick_cnt++;
          case (poll_state)
            POLL_FIRST: begin
              if (tick_cnt >= cfg_shadow.read_timeout_ticks) begin
                poll_state = POLL_IDLE;
                tick_cnt = '0;
              end
            end
            POLL_SETTLE: begin
              if (tick_cnt >= cfg_shadow.settle_ticks) begin
                poll_state = POLL_SECOND;
                tick_cnt = '0;
                push_query();
              end
            end
            default: begin
              // second read gave up: fall back to the first reading
              if (tick_cnt >= cfg_shadow.read_timeout_ticks) begin
                poll_state = POLL_IDLE;
                tick_cnt = '0;
                push_report(first_mm);
              end
            end
          endcase
        end
      end
      CMD_FRAME: begin
        if ((poll_state == POLL_FIRST || poll_state == POLL_SECOND) && reply_ok) begin
          tick_cnt = '0;
          if (poll_state == POLL_FIRST) begin
            first_mm = reply_mm;
            if (cfg_shadow.settle_ticks == '0) begin
              poll_state = POLL_SECOND;
              push_query();
            end else begin
              poll_state = POLL_SETTLE;
            end
          end else begin
            poll_state = POLL_IDLE;
            // keep the first when equal or when only it has a nonzero low byte
            if (first_mm == reply_mm || (first_mm[7:0] != 8'h00 && reply_mm[7:0] == 8'h00)) begin
              push_report(first_mm);
            end else begin
              push_report(reply_mm);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic can_req_t random_req(input logic [1:0] cmd);
    logic [63:0] bits;
    can_req_t    req;
    bits = {$urandom, $urandom};
    req = bits[$bits(can_req_t)-1:0];
    req.cmd = cmd;
    return req;
  endfunction

  function automatic can_req_t reply_frame(input logic [15:0] mm);
    can_req_t req;
    req.cmd = CMD_FRAME;
    req.id = sensor_id();
    req.len = 4'($urandom_range(REPLY_MIN_LEN, 15));
    req.data = {mm[7:0], mm[15:8], REPLY_PAYLOAD_LEN, FUNC_READ_REPLY, cfg_shadow.sensor_address};
    return req;
  endfunction

  // a reply with exactly one thing wrong
  function automatic can_req_t broken_frame(input logic [15:0] mm, input int unsigned which);
    can_req_t req;
    req = reply_frame(mm);
    case (which)
      0: req.id ^= 11'($urandom_range(1, 2047));
      1: req.len = 4'($urandom_range(0, REPLY_MIN_LEN - 1));
      2: req.data[0] ^= 8'($urandom_range(1, 255));
      3: req.data[1] ^= 8'($urandom_range(1, 255));
      4: req.data[2] ^= 8'($urandom_range(1, 255));
      5: {req.data[3], req.data[4]} = VAL_NO_OBJECT;
      default: {req.data[3], req.data[4]} = VAL_INTERFERENCE;
    endcase
    return req;
  endfunction

  function automatic logic [15:0] pick_reading();
    logic [15:0] lo_mm;
    logic [15:0] hi_mm;
    lo_mm = cfg_shadow.min_range_mm;
    hi_mm = cfg_shadow.max_range_mm;
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1, 2: begin
        if (hi_mm >= lo_mm) return lo_mm + 16'($urandom_range(0, hi_mm - lo_mm));
        return 16'($urandom);
      end
      3: return first_mm;
      4: return {8'($urandom), 8'h00};
      5: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'hFFFC;
          default: return lo_mm - 16'd1;
        endcase
      end
      6: return $urandom_range(0, 1) ? hi_mm + 16'd1 : ($urandom_range(0, 1) ? hi_mm : lo_mm);
      default: return 16'($urandom_range(0, 6000));
    endcase
  endfunction

  task automatic send_request(input can_req_t req);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= req.cmd;
    rx_id_i    <= req.id;
    rx_len_i   <= req.len;
    rx_byte0_i <= req.data[0];
    rx_byte1_i <= req.data[1];
    rx_byte2_i <= req.data[2];
    rx_byte3_i <= req.data[3];
    rx_byte4_i <= req.data[4];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_poll_step(req);
  endtask

  // wait until nothing is in flight; requests that give no result need the extra cycles
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_SENSOR_ADDR:  cfg_shadow.sensor_address = value[7:0];
      REG_MIN_RANGE:    cfg_shadow.min_range_mm = value;
      REG_MAX_RANGE:    cfg_shadow.max_range_mm = value;
      REG_READ_TIMEOUT: cfg_shadow.read_timeout_ticks = value;
      REG_SETTLE:       cfg_shadow.settle_ticks = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] addr, input logic [15:0] lo_mm,
                                input logic [15:0] hi_mm, input logic [15:0] timeout,
                                input logic [15:0] settle);
    drain_results();
    cfg_write(REG_SENSOR_ADDR, {8'($urandom), addr});
    cfg_write(REG_MIN_RANGE, lo_mm);
    cfg_write(REG_MAX_RANGE, hi_mm);
    cfg_write(REG_READ_TIMEOUT, timeout);
    cfg_write(REG_SETTLE, settle);
    // index past the register list, must change nothing
    cfg_write(CFG_IDX_W'(int'(REG_SETTLE) +
              $urandom_range(1, (1 << CFG_IDX_W) - 1 - int'(REG_SETTLE))), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_request(random_req(CMD_UNUSED));
    send_request(random_req(CMD_TICK));
    send_request(reply_frame(16'd2000));
    send_request(random_req(CMD_START));
  endtask

  task automatic test_reply_filter();
    apply_settings(8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_request(random_req(CMD_START));
    for (int k = 0; k < BREAK_KINDS; k++) send_request(broken_frame(16'hFF00, k));
    send_request(reply_frame(16'hFF00));
    send_request(random_req(CMD_TICK));
    send_request(random_req(CMD_START));
    send_request(random_req(CMD_TICK));
  endtask

  task automatic test_reconcile();
    logic [15:0] firsts [4];
    logic [15:0] seconds [4];
    firsts  = '{16'h0100, 16'h0105, 16'hFFFF, 16'h0000};
    seconds = '{16'h0100, 16'h0200, 16'h0001, 16'h0300};
    apply_settings(8'h00, 16'h0000, 16'hFFFF, 16'd3, 16'd1);
    for (int k = 0; k < 4; k++) begin
      send_request(random_req(CMD_START));
      send_request(reply_frame(firsts[k]));
      send_request(random_req(CMD_TICK));
      send_request(reply_frame(seconds[k]));
    end
  endtask

  task automatic test_random_polls();
    int unsigned done;
    int unsigned roll;
    logic [15:0] lo_mm;
    logic [15:0] hi_mm;
    can_req_t    req;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_settings(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        1: apply_settings(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
        2: apply_settings(8'($urandom), 16'd0, 16'd6000, 16'($urandom_range(40, 80)),
                          16'($urandom_range(20, 40)));
        default: begin
          lo_mm = 16'($urandom_range(0, 1500));
          hi_mm = lo_mm + 16'($urandom_range(0, 8000));
          if ($urandom_range(0, 3) == 0) begin
            lo_mm = 16'($urandom);
            hi_mm = 16'($urandom);
          end
          apply_settings(8'($urandom), lo_mm, hi_mm, 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 6)));
        end
      endcase
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        case (poll_state)
          POLL_IDLE: begin
            if (roll < 85) req = random_req(CMD_START);
            else if (roll < 92) req = reply_frame(pick_reading());
            else req = random_req(2'($urandom));
          end
          POLL_SETTLE: begin
            if (roll < 80) req = random_req(CMD_TICK);
            else if (roll < 90) req = reply_frame(pick_reading());
            else if (roll < 97) req = random_req(2'($urandom));
            else req = random_req(CMD_START);
          end
          default: begin
            if (roll < 55) req = reply_frame(pick_reading());
            else if (roll < 75) req = random_req(CMD_TICK);
            else if (roll < 88) req = broken_frame(pick_reading(), $urandom_range(0, BREAK_KINDS - 1));
            else if (roll < 97) req = random_req(2'($urandom));
            else req = random_req(CMD_START);
          end
        endcase
        if (poll_state != POLL_IDLE || req.cmd == CMD_START) done++;
        send_request(req);
      end
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    poll_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result without expectation: kind %0d tx_id 0x%03h range_mm %0d",
                 kind_o, tx_id_o, range_mm_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind mismatch: expected %0d, got %0d", want.kind, kind_o);
            mismatches++;
          end
          if (tx_id_o !== want.tx_id) begin
            $error("tx_id mismatch: expected 0x%03h, got 0x%03h", want.tx_id, tx_id_o);
            mismatches++;
          end
          if (range_mm_o !== want.range_mm) begin
            $error("range_mm mismatch: expected %0d, got %0d", want.range_mm, range_mm_o);
            mismatches++;
          end
        end
      end
      if (pattern_pos == '0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hFFFF;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom & $urandom) | (16'd1 << $urandom_range(0, 15));
          default: ready_pattern = 16'($urandom | $urandom);
        endcase
      end
      out_ready_i <= ready_pattern[pattern_pos[3:0]];
      pattern_pos <= pattern_pos + 7'd1;
    end
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_reply_filter();
    test_reconcile();
    test_random_polls();
    drain_results();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
